// ===== rtl/core/scct_pkg.sv =====
// Package for the swept circle collision time block: data path widths.
// No dependencies.
`default_nettype none
package scct_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int D_W     = 33;   // cp, dv
    localparam int HW      = 68;   // h, a, c
    localparam int QW      = 134;  // q
    // root radicand q<<2F, 2F <= 48
    localparam int RADW    = QW + 48;
    localparam int SW      = RADW / 2;
    // divide numerator width
    localparam int NW      = SW + 2;
endpackage
`default_nettype wire

// ===== rtl/core/scct_sqrt_cell.sv =====
// One restoring square root step (two radicand bits, one root bit).
// Depends on scct_pkg.
`default_nettype none
module scct_sqrt_cell
    import scct_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [RADW-1:0] rad_in,
    input  wire logic [SW+1:0]   rem_in,
    input  wire logic [SW-1:0]   root_in,
    output logic [RADW-1:0]      rad_out,
    output logic [SW+1:0]        rem_out,
    output logic [SW-1:0]        root_out
);
    localparam int BIT = SW - 1 - STEP;
    logic [SW+1:0] trial;
    logic [SW+1:0] shifted;
    always_comb begin
        shifted = {rem_in[SW-1:0], rad_in[2*BIT+1 -: 2]};
        trial   = {root_in, 2'b01};
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_out <= rad_in;
            if (shifted >= trial) begin
                rem_out  <= shifted - trial;
                root_out <= {root_in[SW-2:0], 1'b1};
            end else begin
                rem_out  <= shifted;
                root_out <= {root_in[SW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/scct_div_cell.sv =====
// One restoring division step: one quotient bit.
// Depends on scct_pkg.
`default_nettype none
module scct_div_cell
    import scct_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [NW-1:0]   num_in,
    input  wire logic [HW-1:0]   den_in,
    input  wire logic [HW:0]     rem_in,
    input  wire logic [NW-1:0]   quo_in,
    output logic [NW-1:0]        num_out,
    output logic [HW-1:0]        den_out,
    output logic [HW:0]          rem_out,
    output logic [NW-1:0]        quo_out
);
    localparam int BIT = NW - 1 - STEP;
    logic [HW+1:0] sh;
    always_comb sh = {rem_in, num_in[BIT]};
    always_ff @(posedge aclk) begin
        if (en) begin
            num_out <= num_in;
            den_out <= den_in;
            if (sh >= {2'b00, den_in}) begin
                rem_out <= (HW+1)'(sh - {2'b00, den_in});
                quo_out <= {quo_in[NW-2:0], 1'b1};
            end else begin
                rem_out <= sh[HW:0];
                quo_out <= {quo_in[NW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/swept_circle_collision_time.sv =====
// Swept circle contact time: a fully pipelined chain of cells.
// Stages: 7 front stages, SW = 91 root cells, one numerator stage, NW = 93 divide cells, then
// the output register; one request per clock while the output is not stalled.
// The whole chain advances when the output register is free or is taken.
// Reset clears only the valid bits; the data path holds no reset.
`default_nettype none
module swept_circle_collision_time
    import scct_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [31:0]   s_first_pos_x,
    input  wire logic signed [31:0]   s_first_pos_y,
    input  wire logic signed [31:0]   s_second_pos_x,
    input  wire logic signed [31:0]   s_second_pos_y,
    input  wire logic signed [31:0]   s_first_vel_x,
    input  wire logic signed [31:0]   s_first_vel_y,
    input  wire logic signed [31:0]   s_second_vel_x,
    input  wire logic signed [31:0]   s_second_vel_y,
    input  wire logic [30:0]          s_first_radius,
    input  wire logic [30:0]          s_second_radius,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    output logic signed [31:0]        m_contact_time,
    output logic                      m_time_clamped
);
    localparam int PRE = 7;
    localparam int PH = HW / 2;
    localparam int DEPTH = PRE + SW + 1 + NW;
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    // stage 1: differences
    logic signed [D_W-1:0] cx_reg, cy_reg, vx_reg, vy_reg;
    logic [RAD_W:0] r_reg;
    // stage 2: products
    logic signed [2*D_W-1:0] pcx_reg, pcy_reg, pvx_reg, pvy_reg, hx_reg, hy_reg;
    logic [2*RAD_W+1:0] rr_reg;
    // stage 3: h, a, c
    logic signed [HW-1:0] h3_reg, a3_reg, c3_reg;
    // stage 4: magnitudes for the q products
    logic signed [HW-1:0] h4_reg, a4_reg;
    logic [HW-1:0] habs4_reg, cabs4_reg;
    logic cneg4_reg;
    // stage 5: half-width partial products of h*h and a*|c|
    logic [2*PH-1:0] phh5_reg, phl5_reg, pll5_reg;
    logic [2*PH-1:0] pahh5_reg, pahl5_reg, palh5_reg, pall5_reg;
    logic signed [HW-1:0] h5_reg, a5_reg;
    logic cneg5_reg, ok5_reg;
    // stage 6: h*h and a*|c|
    logic [QW-1:0] hh6_reg, acm6_reg;
    logic signed [HW-1:0] h6_reg, a6_reg;
    logic cneg6_reg, ok6_reg;
    // stage 7: q, scaled radicand
    logic signed [QW-1:0] q7_next;
    logic [RADW-1:0] rad7_reg;
    logic signed [HW-1:0] h7_reg, a7_reg;
    logic ok7_reg;

    always_comb q7_next = cneg6_reg ? hh6_reg + acm6_reg : hh6_reg - acm6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg <= D_W'(s_first_pos_x) - D_W'(s_second_pos_x);
            cy_reg <= D_W'(s_first_pos_y) - D_W'(s_second_pos_y);
            vx_reg <= D_W'(s_first_vel_x) - D_W'(s_second_vel_x);
            vy_reg <= D_W'(s_first_vel_y) - D_W'(s_second_vel_y);
            r_reg  <= {1'b0, s_first_radius} + {1'b0, s_second_radius};
            pcx_reg <= cx_reg * cx_reg;
            pcy_reg <= cy_reg * cy_reg;
            pvx_reg <= vx_reg * vx_reg;
            pvy_reg <= vy_reg * vy_reg;
            hx_reg  <= cx_reg * vx_reg;
            hy_reg  <= cy_reg * vy_reg;
            rr_reg  <= r_reg * r_reg;
            h3_reg <= HW'(hx_reg) + HW'(hy_reg);
            a3_reg <= HW'(pvx_reg) + HW'(pvy_reg);
            c3_reg <= HW'(pcx_reg) + HW'(pcy_reg) - HW'($signed({1'b0, rr_reg}));
            h4_reg    <= h3_reg;
            a4_reg    <= a3_reg;
            habs4_reg <= h3_reg[HW-1] ? $unsigned(-h3_reg) : $unsigned(h3_reg);
            cabs4_reg <= c3_reg[HW-1] ? $unsigned(-c3_reg) : $unsigned(c3_reg);
            cneg4_reg <= c3_reg[HW-1];
            phh5_reg  <= habs4_reg[HW-1:PH] * habs4_reg[HW-1:PH];
            phl5_reg  <= habs4_reg[HW-1:PH] * habs4_reg[PH-1:0];
            pll5_reg  <= habs4_reg[PH-1:0] * habs4_reg[PH-1:0];
            pahh5_reg <= a4_reg[HW-1:PH] * cabs4_reg[HW-1:PH];
            pahl5_reg <= a4_reg[HW-1:PH] * cabs4_reg[PH-1:0];
            palh5_reg <= a4_reg[PH-1:0] * cabs4_reg[HW-1:PH];
            pall5_reg <= a4_reg[PH-1:0] * cabs4_reg[PH-1:0];
            h5_reg    <= h4_reg;
            a5_reg    <= a4_reg;
            cneg5_reg <= cneg4_reg;
            ok5_reg   <= h4_reg[HW-1];
            // cross term of the square appears twice
            hh6_reg  <= (QW'(phh5_reg) << (2 * PH)) + (QW'(phl5_reg) << (PH + 1))
                      + QW'(pll5_reg);
            acm6_reg <= (QW'(pahh5_reg) << (2 * PH))
                      + ((QW'(pahl5_reg) + QW'(palh5_reg)) << PH) + QW'(pall5_reg);
            h6_reg    <= h5_reg;
            a6_reg    <= a5_reg;
            cneg6_reg <= cneg5_reg;
            ok6_reg   <= ok5_reg;
            rad7_reg <= RADW'(q7_next) << (2 * FRAC_BITS);
            h7_reg  <= h6_reg;
            a7_reg  <= a6_reg;
            ok7_reg <= ok6_reg && !q7_next[QW-1];
        end
    end

    // root chain, with h, a, hit riding alongside
    logic [RADW-1:0] rad_c [SW+1];
    logic [SW+1:0]   rem_c [SW+1];
    logic [SW-1:0]   root_c[SW+1];
    logic signed [HW-1:0] hs_reg[SW+1];
    logic signed [HW-1:0] as_reg[SW+1];
    logic oks_reg[SW+1];
    assign rad_c[0] = rad7_reg;
    assign rem_c[0] = '0;
    assign root_c[0] = '0;
    assign hs_reg[0] = h7_reg;
    assign as_reg[0] = a7_reg;
    assign oks_reg[0] = ok7_reg;
    for (genvar i = 0; i < SW; i++) begin : g_root
        scct_sqrt_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .en(adv),
            .rad_in(rad_c[i]), .rem_in(rem_c[i]), .root_in(root_c[i]),
            .rad_out(rad_c[i+1]), .rem_out(rem_c[i+1]), .root_out(root_c[i+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                hs_reg[i+1] <= hs_reg[i];
                as_reg[i+1] <= as_reg[i];
                oks_reg[i+1] <= oks_reg[i];
            end
        end
    end

    // numerator -h<<F - s and its sign
    logic signed [NW:0] num_full;
    logic [NW-1:0] num_abs;
    logic neg_num;
    always_comb begin
        num_full = ((NW+1)'(-hs_reg[SW]) <<< FRAC_BITS)
                 - (NW+1)'({1'b0, root_c[SW]});
        neg_num  = num_full[NW];
        num_abs  = neg_num ? NW'(-num_full) : num_full[NW-1:0];
    end

    logic [NW-1:0] numa_reg;
    logic numneg_reg;
    logic [HW-1:0] den_reg;
    logic okn_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            numa_reg   <= num_abs;
            numneg_reg <= neg_num;
            den_reg    <= as_reg[SW];
            okn_reg    <= oks_reg[SW];
        end
    end

    logic [NW-1:0] nm_c[NW+1];
    logic [HW-1:0] dn_c[NW+1];
    logic [HW:0]   rm_c[NW+1];
    logic [NW-1:0] qo_c[NW+1];
    logic neg_reg[NW+1];
    logic okd_reg[NW+1];
    assign nm_c[0] = numa_reg;
    assign dn_c[0] = den_reg;
    assign rm_c[0] = '0;
    assign qo_c[0] = '0;
    assign neg_reg[0] = numneg_reg;
    assign okd_reg[0] = okn_reg;
    for (genvar j = 0; j < NW; j++) begin : g_div
        scct_div_cell #(.STEP(j)) u_cell (
            .aclk(aclk), .en(adv),
            .num_in(nm_c[j]), .den_in(dn_c[j]), .rem_in(rm_c[j]), .quo_in(qo_c[j]),
            .num_out(nm_c[j+1]), .den_out(dn_c[j+1]), .rem_out(rm_c[j+1]),
            .quo_out(qo_c[j+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[j+1] <= neg_reg[j];
                okd_reg[j+1] <= okd_reg[j];
            end
        end
    end

    // round negative quotients away from zero (floor), then saturate
    logic [NW:0] mag;
    logic [31:0] t_next;
    logic clamp_next;
    always_comb begin
        mag = {1'b0, qo_c[NW]} + (NW+1)'(neg_reg[NW] && (rm_c[NW] != '0));
        clamp_next = 1'b0;
        if (!neg_reg[NW]) begin
            if (mag > (NW+1)'(32'h7FFF_FFFF)) begin
                t_next = 32'h7FFF_FFFF;
                clamp_next = 1'b1;
            end else begin
                t_next = mag[31:0];
            end
        end else begin
            if (mag > (NW+1)'(32'h8000_0000)) begin
                t_next = 32'h8000_0000;
                clamp_next = 1'b1;
            end else begin
                t_next = 32'd0 - mag[31:0];
            end
        end
        if (!okd_reg[NW]) begin
            t_next = '0;
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_valid <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
            m_valid <= vld_reg[DEPTH-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_hit <= okd_reg[NW];
            m_contact_time <= t_next;
            m_time_clamped <= clamp_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_contact_time))
        else $error("result changed while stalled");
    a_clamp_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_time_clamped |-> m_hit)
        else $error("clamp without hit");
    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_contact_time == 32'd0)
        else $error("time nonzero without hit");
endmodule
`default_nettype wire
